/* rtl/m4fx_pkg.sv */
// Package with opcodes and shared types for the 4x4 fixed-point matrix unit.
package m4fx_pkg;

    typedef enum logic [3:0] {
        OP_WR_ACC = 4'd0,
        OP_WR_OPD = 4'd1,
        OP_RD_ACC = 4'd2,
        OP_IDENT  = 4'd3,
        OP_COPY   = 4'd4,
        OP_ADD    = 4'd5,
        OP_SUB    = 4'd6,
        OP_MUL    = 4'd7,
        OP_SCALE  = 4'd8,
        OP_NEG    = 4'd9,
        OP_TRANSP = 4'd10,
        OP_VEC    = 4'd11
    } opcode_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [1:0]  row;
        logic [1:0]  column;
        logic [31:0] value;
        logic [31:0] vec_x;
        logic [31:0] vec_y;
        logic [31:0] vec_z;
        logic [31:0] vec_w;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
        logic        overflow;
    } out_item_t;

endpackage

/* rtl/m4fx_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
interface m4fx_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/m4fx_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module m4fx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/matrix4_fixed_point_unit.sv */
// Top level of the 4x4 fixed-point matrix unit: sequencer around two matrix RAMs.
// Writes and unused opcodes go from S_RD straight to S_OUT; reads and matrix ops pass
// through S_WAIT and S_CALC, and all but a read write back each element in S_WB. One item
// at a time; the next transfer is taken from the cycle after the result is loaded. After
// reset a clearing pass writes identity into both RAMs with input ready low; results empty at once.
module matrix4_fixed_point_unit #(
    parameter int DIM       = 4,
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    m4fx_stream_if.sink   in_ch,
    m4fx_stream_if.source out_ch
);
    import m4fx_pkg::*;

    localparam int NE = DIM * DIM;
    localparam int AW = $clog2(NE);
    localparam int DW = $clog2(DIM);
    localparam int PW = 2 * WORD_BITS;
    localparam int SW = PW + 4;
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE =
        (FRAC_BITS >= WORD_BITS - 1) ? WMAX : WORD_BITS'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_WAIT, S_CALC, S_WB, S_OUT} state_t;

    state_t   state_reg;
    in_item_t item_reg;
    logic [AW-1:0] idx_reg;
    logic [DW-1:0] ii_reg;
    logic [DW-1:0] jj_reg;
    logic [DW-1:0] k_reg;
    logic [DW-1:0] vi_reg;
    logic [SW-1:0] sum_reg;
    logic          ovf_reg;
    logic          init_sel_reg;
    logic          ov_valid_reg;
    out_item_t     out_reg;
    logic signed [WORD_BITS-1:0] res_reg [4];

    // RAM ports.
    logic                 a_we, o_we;
    logic [AW-1:0]        a_wa, o_wa, a_ra, o_ra;
    logic [WORD_BITS-1:0] a_wd, o_wd, a_rd, o_rd;

    m4fx_ram #(.WIDTH(WORD_BITS), .DEPTH(NE)) u_acc (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    m4fx_ram #(.WIDTH(WORD_BITS), .DEPTH(NE)) u_opd (
        .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

    // Index helpers: row and column of the current element.
    logic [DW-1:0] ii, jj;
    opcode_t op;
    assign ii = ii_reg;
    assign jj = jj_reg;
    assign op = opcode_t'(item_reg.opcode);

    logic in_rng;
    assign in_rng = (32'(item_reg.row) < DIM) && (32'(item_reg.column) < DIM);
    logic [AW-1:0] el_addr;
    assign el_addr = AW'(32'(item_reg.row) * DIM + 32'(item_reg.column));

    // Saturate a 32-bit input to the word width.
    function automatic logic signed [WORD_BITS-1:0] sat_in(input logic signed [31:0] v,
                                                          output logic o);
        logic signed [PW+31:0] e;
        begin
            e = (PW+32)'(v);
            o = 1'b0;
            if (e > (PW+32)'(WMAX))
            begin
                o = 1'b1;
                sat_in = WMAX;
            end
            else if (e < (PW+32)'(WMIN))
            begin
                o = 1'b1;
                sat_in = WMIN;
            end
            else
            begin
                sat_in = WORD_BITS'(e);
            end
        end
    endfunction

    logic signed [WORD_BITS-1:0] vin_sat;
    logic vin_ovf;
    always_comb
    begin
        vin_sat = sat_in(item_reg.value, vin_ovf);
    end

    // Vector element selected by k, taken as 32 bits without saturation.
    logic signed [31:0] vsel;
    always_comb
    begin
        unique case (32'(k_reg))
            0:       vsel = item_reg.vec_x;
            1:       vsel = item_reg.vec_y;
            2:       vsel = item_reg.vec_z;
            default: vsel = item_reg.vec_w;
        endcase
    end

    // Row buffer holds the old accumulator row while a matrix product overwrites it.
    logic signed [WORD_BITS-1:0] rowbuf_reg [DIM];

    // Shared multiplier and accumulator path.
    logic signed [WORD_BITS-1:0] mul_a;
    logic signed [WORD_BITS-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] prod_t, sum_new;
    always_comb
    begin
        if (op == OP_MUL && jj != '0)
        begin
            mul_a = rowbuf_reg[k_reg];
        end
        else
        begin
            mul_a = signed'(a_rd);
        end
        if (op == OP_SCALE)
        begin
            mul_b = WORD_BITS'(signed'(item_reg.value));
        end
        else if (op == OP_VEC)
        begin
            mul_b = WORD_BITS'(vsel);
        end
        else
        begin
            mul_b = signed'(o_rd);
        end
        prod = PW'(mul_a) * PW'(mul_b);
        prod_t = SW'(prod >>> FRAC_BITS);
        sum_new = signed'(sum_reg) + prod_t;
    end

    // Saturation of a wide sum to the word width and to 32 bits.
    logic signed [WORD_BITS-1:0] wsat;
    logic wovf;
    logic signed [31:0] osat;
    logic oovf;
    always_comb
    begin
        wovf = 1'b0;
        if (signed'(sum_reg) > SW'(WMAX))
        begin
            wsat = WMAX;
            wovf = 1'b1;
        end
        else if (signed'(sum_reg) < SW'(WMIN))
        begin
            wsat = WMIN;
            wovf = 1'b1;
        end
        else
        begin
            wsat = WORD_BITS'(sum_reg);
        end
    end
    function automatic logic signed [31:0] to32(input logic signed [WORD_BITS-1:0] v,
                                               output logic o);
        logic signed [WORD_BITS+32:0] e;
        begin
            e = (WORD_BITS+33)'(v);
            o = 1'b0;
            if (e > (WORD_BITS+33)'(33'sh07FFFFFFF))
            begin
                o = 1'b1;
                to32 = 32'sh7FFFFFFF;
            end
            else if (e < -(WORD_BITS+33)'(33'sh080000000))
            begin
                o = 1'b1;
                to32 = 32'sh80000000;
            end
            else
            begin
                to32 = 32'(e);
            end
        end
    endfunction
    always_comb
    begin
        osat = to32(wsat, oovf);
    end

    // Element read narrowed to 32 bits.
    logic signed [31:0] rd32;
    logic rdovf;
    always_comb
    begin
        rd32 = to32(signed'(a_rd), rdovf);
    end

    // Read addresses: depend on state and opcode.
    always_comb
    begin
        a_ra = idx_reg;
        o_ra = idx_reg;
        if (op == OP_MUL)
        begin
            a_ra = AW'(32'(ii) * DIM + 32'(k_reg));
            o_ra = AW'(32'(k_reg) * DIM + 32'(jj));
        end
        else if (op == OP_VEC)
        begin
            a_ra = AW'(32'(vi_reg) * DIM + 32'(k_reg));
        end
        else if (op == OP_TRANSP && k_reg != '0)
        begin
            a_ra = AW'(32'(jj) * DIM + 32'(ii));
        end
        else if (op == OP_RD_ACC)
        begin
            a_ra = el_addr;
        end
    end

    // Element counters advance in row-major order.
    logic last_k;
    assign last_k = (32'(k_reg) == DIM - 1);
    logic last_idx;
    assign last_idx = (32'(idx_reg) == NE - 1);
    logic [AW-1:0] idx_next;
    logic [DW-1:0] ii_next, jj_next;
    always_comb
    begin
        if (last_idx)
        begin
            idx_next = '0;
            ii_next  = '0;
            jj_next  = '0;
        end
        else if (32'(jj_reg) == DIM - 1)
        begin
            idx_next = idx_reg + 1'b1;
            ii_next  = ii_reg + 1'b1;
            jj_next  = '0;
        end
        else
        begin
            idx_next = idx_reg + 1'b1;
            ii_next  = ii_reg;
            jj_next  = jj_reg + 1'b1;
        end
    end

    // Write ports.
    always_comb
    begin
        a_we = 1'b0;
        o_we = 1'b0;
        a_wa = idx_reg;
        o_wa = idx_reg;
        a_wd = wsat;
        o_wd = vin_sat;
        if (state_reg == S_INIT)
        begin
            a_we = !init_sel_reg;
            o_we = init_sel_reg;
            a_wd = (ii == jj) ? ONE : '0;
            o_wd = (ii == jj) ? ONE : '0;
        end
        else if (state_reg == S_WB)
        begin
            a_we = (op != OP_VEC) && (op != OP_TRANSP || ii < jj);
        end
        else if (state_reg == S_CALC && op == OP_TRANSP)
        begin
            // The mirrored element takes the old value of this one.
            a_we = (k_reg != '0);
            a_wa = AW'(32'(jj) * DIM + 32'(ii));
            a_wd = wsat;
        end
        else if (state_reg == S_IDLE)
        begin
            a_we = 1'b0;
        end
        else if (state_reg == S_RD)
        begin
            a_we = (op == OP_WR_ACC) && in_rng;
            o_we = (op == OP_WR_OPD) && in_rng;
            a_wa = el_addr;
            o_wa = el_addr;
            a_wd = vin_sat;
        end
        if (state_reg == S_WB)
        begin
            unique case (op)
                OP_IDENT:  a_wd = (ii == jj) ? vin_sat : '0;
                OP_COPY:   a_wd = o_rd;
                default:   a_wd = wsat;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            item_reg     <= '0;
            idx_reg      <= '0;
            ii_reg       <= '0;
            jj_reg       <= '0;
            k_reg        <= '0;
            vi_reg       <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            init_sel_reg <= 1'b0;
            ov_valid_reg <= 1'b0;
            out_reg      <= '0;
            for (int n = 0; n < 4; n++)
            begin
                res_reg[n] <= '0;
            end
        end
        else
        begin
            // The result register fills from S_OUT and empties on a transfer.
            if (state_reg == S_OUT && (!ov_valid_reg || out_ch.ready))
            begin
                ov_valid_reg <= 1'b1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                ov_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    idx_reg <= idx_next;
                    ii_reg  <= ii_next;
                    jj_reg  <= jj_next;
                    if (last_idx)
                    begin
                        init_sel_reg <= 1'b1;
                        if (init_sel_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg  <= in_ch.data;
                        idx_reg   <= '0;
                        ii_reg    <= '0;
                        jj_reg    <= '0;
                        k_reg     <= '0;
                        vi_reg    <= '0;
                        sum_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // Element writes and unused opcodes finish here; the others wait for read data.
                    for (int n = 0; n < 4; n++)
                    begin
                        res_reg[n] <= '0;
                    end
                    if (op == OP_WR_ACC || op == OP_WR_OPD)
                    begin
                        ovf_reg   <= in_rng && vin_ovf;
                        state_reg <= S_OUT;
                    end
                    else if (op == OP_RD_ACC || op == OP_IDENT || op == OP_COPY ||
                             op == OP_ADD || op == OP_SUB || op == OP_MUL ||
                             op == OP_SCALE || op == OP_NEG || op == OP_TRANSP ||
                             op == OP_VEC)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    unique case (op)
                        OP_RD_ACC:
                        begin
                            if (in_rng)
                            begin
                                res_reg[0] <= rd32;
                                ovf_reg    <= rdovf;
                            end
                            state_reg <= S_OUT;
                        end
                        OP_IDENT:
                        begin
                            ovf_reg   <= vin_ovf;
                            state_reg <= S_WB;
                        end
                        OP_ADD:
                        begin
                            sum_reg   <= SW'(signed'(a_rd)) + SW'(signed'(o_rd));
                            state_reg <= S_WB;
                        end
                        OP_SUB:
                        begin
                            sum_reg   <= SW'(signed'(a_rd)) - SW'(signed'(o_rd));
                            state_reg <= S_WB;
                        end
                        OP_NEG:
                        begin
                            sum_reg   <= -SW'(signed'(a_rd));
                            state_reg <= S_WB;
                        end
                        OP_SCALE:
                        begin
                            sum_reg   <= prod_t;
                            state_reg <= S_WB;
                        end
                        OP_TRANSP:
                        begin
                            // Above the diagonal, read the element, then its mirror.
                            sum_reg <= SW'(signed'(a_rd));
                            if (ii < jj && k_reg == '0)
                            begin
                                k_reg     <= DW'(1);
                                state_reg <= S_WAIT;
                            end
                            else
                            begin
                                k_reg     <= '0;
                                state_reg <= S_WB;
                            end
                        end
                        OP_MUL, OP_VEC:
                        begin
                            sum_reg <= sum_new;
                            if (last_k)
                            begin
                                k_reg     <= '0;
                                state_reg <= S_WB;
                            end
                            else
                            begin
                                k_reg     <= k_reg + 1'b1;
                                state_reg <= S_WAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_WB;
                        end
                    endcase
                end
                S_WB:
                begin
                    sum_reg <= '0;
                    if (op == OP_VEC)
                    begin
                        res_reg[vi_reg] <= osat;
                        ovf_reg <= ovf_reg | wovf | oovf;
                        if (32'(vi_reg) == DIM - 1)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            vi_reg    <= vi_reg + 1'b1;
                            state_reg <= S_WAIT;
                        end
                    end
                    else
                    begin
                        if (op == OP_ADD || op == OP_SUB || op == OP_NEG ||
                            op == OP_SCALE || op == OP_MUL)
                        begin
                            ovf_reg <= ovf_reg | wovf;
                        end
                        if (last_idx)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_next;
                            ii_reg    <= ii_next;
                            jj_reg    <= jj_next;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_valid_reg || out_ch.ready)
                    begin
                        out_reg.out_x    <= res_reg[0];
                        out_reg.out_y    <= res_reg[1];
                        out_reg.out_z    <= res_reg[2];
                        out_reg.out_w    <= res_reg[3];
                        out_reg.overflow <= ovf_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the old accumulator row on the first column of a matrix product.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC && op == OP_MUL && jj == '0)
        begin
            rowbuf_reg[k_reg] <= signed'(a_rd);
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ov_valid_reg;
    assign out_ch.data  = out_reg;
endmodule

/* rtl/m4fx_checker.sv */
// Port-level checker for the matrix unit, bound to the top level.
module m4fx_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Input is refused in the cycle after a transfer.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted two items back to back");

    // No result appears in the cycle after an input transfer.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");
endmodule

bind matrix4_fixed_point_unit m4fx_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready));
